// ===== rtl/core/indexed_list_store_defines.svh =====
// Assertion macros shared by the indexed list store RTL.
// Each macro takes a label, an antecedent, a consequent and a message.
// Clock is clock, reset is reset (active high) in every user.
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

// Same-cycle implication
`define ILS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define ILS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Types and constants of the indexed list store: transfer payloads, the
// command broadcast to the row of storage cells, and operation codes.
// ----------------------------------------------------------------------------
package ils_pkg;

   // Store geometry
   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths
   localparam int MODE_W  = 2;
   localparam int POS_W   = 5;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 5;
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_DUMP   = 2'd2
   } mode_type;

   // Status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   // Per-cycle operation of the cell row
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic [IDX_W-1:0]         pos;
      logic [CNT_W-1:0]         count;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     status;
      logic signed [DATA_W-1:0] entry_value;
      logic                     has_value;
      logic                     last;
      logic [COUNT_W-1:0]       count;
   } rsp_type;

endpackage

// ===== rtl/core/ils_cell.sv =====
// ----------------------------------------------------------------------------
// ils_cell
// One storage cell of the row. Holds one entry and, per broadcast command,
// keeps it, loads the new value, or takes a neighbor's entry or the old head.
// ----------------------------------------------------------------------------
module ils_cell (
   input  logic                             clock,
   input  ils_pkg::cell_cmd_type            cmd,
   input  logic [ils_pkg::IDX_W-1:0]        cell_idx,
   input  logic signed [ils_pkg::DATA_W-1:0] left_q,
   input  logic signed [ils_pkg::DATA_W-1:0] right_q,
   input  logic signed [ils_pkg::DATA_W-1:0] head_q,
   output logic signed [ils_pkg::DATA_W-1:0] q
);
   import ils_pkg::*;

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic [CNT_W-1:0]         idx_next;

   assign idx_next = CNT_W'(cell_idx) + CNT_W'(1);

   // Next entry from the broadcast command
   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (cell_idx == cmd.pos) begin
               entry_in = cmd.value;
            end else if (cell_idx > cmd.pos) begin
               entry_in = left_q;
            end
         end
         CELL_DELETE: begin
            if (cell_idx >= cmd.pos) begin
               entry_in = right_q;
            end
         end
         CELL_ROTATE: begin
            // last occupied cell wraps around to the old head
            if (idx_next == cmd.count) begin
               entry_in = head_q;
            end else begin
               entry_in = right_q;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

// ===== rtl/core/ils_chain.sv =====
// ----------------------------------------------------------------------------
// ils_chain
// Row of storage cells, each wired to its left and right neighbor. Entry 0
// sits in the first cell and is presented as the head.
// ----------------------------------------------------------------------------
module ils_chain (
   input  logic                              clock,
   input  ils_pkg::cell_cmd_type             cmd,
   output logic signed [ils_pkg::DATA_W-1:0] head
);
   import ils_pkg::*;

   logic signed [DATA_W-1:0] cell_q [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_q;
      logic signed [DATA_W-1:0] right_q;

      // Edge cells see themselves where no neighbor exists
      if (i == 0) begin : g_first
         assign left_q = cell_q[0];
      end else begin : g_mid_l
         assign left_q = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_lastc
         assign right_q = cell_q[i];
      end else begin : g_mid_r
         assign right_q = cell_q[i+1];
      end

      ils_cell u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .cell_idx (IDX_W'(i)),
         .left_q   (left_q),
         .right_q  (right_q),
         .head_q   (cell_q[0]),
         .q        (cell_q[i])
      );
   end

   assign head = cell_q[0];

endmodule

// ===== rtl/core/indexed_list_store.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store
// Bounded ordered store of signed 32-bit entries with insert and delete at
// an index and an in-order dump, built on a row of shifting cells.
// ----------------------------------------------------------------------------
//   Channel   Dir   Payload    Transfer when
//   req       in    req_type   req_valid & req_ready
//   rsp       out   rsp_type   rsp_valid & rsp_ready
//
// An insert or delete shifts the whole cell row in the cycle that accepts
// the request; an error item leaves the row as it is. A dump takes the
// request, then rotates the cell row by one cell per emitted entry. It blocks
// new requests until its last result is registered. An empty dump gives one
// result with no value. Reset clears the entry count and state; cell contents
// need no reset. A stalled rsp holds the output register and the cell row.
// ----------------------------------------------------------------------------
module indexed_list_store (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ils_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ils_pkg::rsp_type rsp_data
);
   import ils_pkg::*;

`include "indexed_list_store_defines.svh"

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   cell_cmd_type             cmd;
   logic signed [DATA_W-1:0] head;
   logic                     out_free;
   logic                     req_accept;
   logic [CMP_W-1:0]         pos_x;
   logic [CMP_W-1:0]         count_x;
   logic                     ins_ok;
   logic                     del_ok;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign req_accept = req_valid && req_ready;

   // Position checks against the current count
   assign pos_x   = CMP_W'(req_data.position);
   assign count_x = CMP_W'(count_ff);
   assign ins_ok  = (count_ff < CNT_W'(CAPACITY)) &&
                    ((count_ff == '0) || (pos_x <= count_x));
   assign del_ok  = (count_ff != '0) && (pos_x < count_x);

   // Control: decode requests, sequence dumps, load the output register
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      remain_in       = remain_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_in          = rsp_ff;
      cmd.op          = CELL_HOLD;
      cmd.pos         = IDX_W'(req_data.position);
      cmd.count       = count_ff;
      cmd.value       = req_data.value;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_in.status      = STATUS_OK;
               rsp_in.entry_value = '0;
               rsp_in.has_value   = 1'b0;
               rsp_in.last        = 1'b1;
               rsp_in.count       = COUNT_W'(count_ff);
               rsp_valid_in       = 1'b1;
               case (req_data.mode)
                  MODE_INSERT: begin
                     if (ins_ok) begin
                        cmd.op       = CELL_INSERT;
                        if (count_ff == '0) begin
                           cmd.pos = '0;
                        end
                        count_in     = count_ff + CNT_W'(1);
                        rsp_in.count = COUNT_W'(count_ff + CNT_W'(1));
                     end else begin
                        rsp_in.status = STATUS_ERR;
                     end
                  end
                  MODE_DELETE: begin
                     if (del_ok) begin
                        cmd.op       = CELL_DELETE;
                        count_in     = count_ff - CNT_W'(1);
                        rsp_in.count = COUNT_W'(count_ff - CNT_W'(1));
                     end else begin
                        rsp_in.status = STATUS_ERR;
                     end
                  end
                  MODE_DUMP: begin
                     if (count_ff != '0) begin
                        rsp_valid_in = rsp_valid_ff && !rsp_ready;
                        rsp_in       = rsp_ff;
                        remain_in    = count_ff;
                        state_in     = ST_DUMP;
                     end
                  end
                  default: begin
                     rsp_in.status = STATUS_ERR;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            // Emit the head, then rotate the row by one cell
            if (out_free) begin
               rsp_in.status      = STATUS_OK;
               rsp_in.entry_value = head;
               rsp_in.has_value   = 1'b1;
               rsp_in.last        = (remain_ff == CNT_W'(1));
               rsp_in.count       = COUNT_W'(count_ff);
               rsp_valid_in       = 1'b1;
               cmd.op             = CELL_ROTATE;
               remain_in          = remain_ff - CNT_W'(1);
               if (remain_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   ils_chain u_chain (
      .clock (clock),
      .cmd   (cmd),
      .head  (head)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `ILS_ASSERT_IMP(a_dump_remain, state_ff == ST_DUMP,
      (remain_ff != '0) && (remain_ff <= count_ff), "dump remainder out of range")
   `ILS_ASSERT_NXT(a_full_insert,
      req_accept && (req_data.mode == MODE_INSERT) && (count_ff == CNT_W'(CAPACITY)),
      rsp_valid && (rsp_data.status == STATUS_ERR), "insert into full store not rejected")
   `ILS_ASSERT_IMP(a_mid_dump, rsp_valid && !rsp_data.last, state_ff == ST_DUMP,
      "non-final result outside a dump")
   `ILS_ASSERT_NXT(a_first_insert,
      req_accept && (req_data.mode == MODE_INSERT) && (count_ff == '0),
      count_ff == CNT_W'(1), "insert into empty store lost")

endmodule

// ===== bench/indexed_list_store_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_tb
// Self-checking bench for the indexed list store. It starts with a short
// directed sequence that covers empty, single-entry and full stores and
// every error path. Random traffic follows, mostly well-formed, in phases
// with and without sender gaps and receiver back-pressure. Each accepted
// request is run through a shadow copy of the list, and every result
// transfer is checked field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module indexed_list_store_tb;
   import ils_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_PRINTED    = 30;
   localparam int DRAIN_CYCLES   = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Shadow of the stored list, lowest index first
   logic signed [DATA_W-1:0] shadow_list[$];
   // Results still owed by the block, in arrival order
   rsp_type                  due_rsps[$];

   int fail_count    = 0;
   int quiet_cycles  = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   indexed_list_store DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= MAX_PRINTED) begin
         $display("%0t ERROR: %s", $realtime, msg);
      end
   endtask

   // Apply one request to the shadow list and queue the results it causes
   task automatic apply_list_op(input req_type rq);
      rsp_type     r;
      int unsigned pos;
      int unsigned sz;
      r      = '0;
      r.last = 1'b1;
      pos    = 32'(rq.position);
      sz     = shadow_list.size();
      case (rq.mode)
         MODE_INSERT: begin
            // an empty store takes any position as the head
            if (sz == 0) pos = 0;
            if (sz >= CAPACITY || pos > sz) begin
               r.status = STATUS_ERR;
            end else begin
               shadow_list.insert(pos, rq.value);
            end
         end
         MODE_DELETE: begin
            if (pos >= sz) begin
               r.status = STATUS_ERR;
            end else begin
               shadow_list.delete(pos);
            end
         end
         MODE_DUMP: begin
            r.status = STATUS_OK;
         end
         default: begin
            r.status = STATUS_ERR;
         end
      endcase
      r.count = COUNT_W'(shadow_list.size());
      if (rq.mode == MODE_DUMP && sz != 0) begin
         for (int i = 0; i < sz; i++) begin
            r.entry_value = shadow_list[i];
            r.has_value   = 1'b1;
            r.last        = (i == sz - 1);
            due_rsps.push_back(r);
         end
      end else begin
         due_rsps.push_back(r);
      end
   endtask

   // Send one request; the shadow list is updated at its transfer
   task automatic send_item(input req_type rq);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_list_op(rq);
   endtask

   function automatic req_type make_req(input logic [MODE_W-1:0] mode,
                                        input logic [POS_W-1:0] position,
                                        input logic signed [DATA_W-1:0] value);
      req_type rq;
      rq.mode     = mode;
      rq.position = position;
      rq.value    = value;
      return rq;
   endfunction

   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(0, 15))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly in-range inserts and deletes, some dumps, some noise
   function automatic req_type random_list_req();
      req_type     rq;
      int unsigned sz;
      int unsigned roll;
      logic        grow;
      sz       = shadow_list.size();
      rq.value = random_value();
      roll     = $urandom_range(0, 99);
      if (roll < 10) begin
         rq.mode     = MODE_DUMP;
         rq.position = POS_W'($urandom);
      end else if (roll < 20) begin
         rq.mode     = MODE_W'($urandom_range(0, 3));
         rq.position = POS_W'($urandom_range(0, 31));
      end else begin
         grow = ($urandom_range(0, CAPACITY) >= sz);
         if (sz == 0) grow = 1'b1;
         if (sz >= CAPACITY) grow = 1'b0;
         if (grow) begin
            rq.mode     = MODE_INSERT;
            rq.position = POS_W'($urandom_range(0, sz));
         end else begin
            rq.mode     = MODE_DELETE;
            rq.position = POS_W'($urandom_range(0, sz - 1));
         end
      end
      return rq;
   endfunction

   // Result checking and the no-progress counter
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (due_rsps.size() == 0) begin
               report_mismatch($sformatf("result transfer with none expected: %p", rsp_data));
            end else begin
               want = due_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status got %0b want %0b",
                                            rsp_data.status, want.status));
               if (rsp_data.entry_value !== want.entry_value)
                  report_mismatch($sformatf("entry_value got %0d want %0d",
                                            rsp_data.entry_value, want.entry_value));
               if (rsp_data.has_value !== want.has_value)
                  report_mismatch($sformatf("has_value got %0b want %0b",
                                            rsp_data.has_value, want.has_value));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("last got %0b want %0b",
                                            rsp_data.last, want.last));
               if (rsp_data.count !== want.count)
                  report_mismatch($sformatf("count got %0d want %0d",
                                            rsp_data.count, want.count));
            end
         end
      end
   end

   // Edges of the list: empty, single entry, head, tail, bad positions
   task automatic test_directed_cases();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_item(make_req(MODE_DUMP, 5'd0, '0));            // empty dump
      send_item(make_req(MODE_DELETE, 5'd0, $urandom));    // delete from empty
      send_item(make_req(MODE_INSERT, 5'd31, 32'sh7FFF_FFFF)); // empty, any position
      send_item(make_req(MODE_DUMP, 5'd31, '0));
      send_item(make_req(MODE_DELETE, 5'd0, '0));          // delete only entry
      send_item(make_req(MODE_INSERT, 5'd9, 32'sh8000_0000));
      send_item(make_req(MODE_INSERT, 5'd0, -32'sd1));     // head
      send_item(make_req(MODE_INSERT, 5'd2, '0));          // tail
      send_item(make_req(MODE_INSERT, 5'd1, 32'sh5555_5555)); // middle
      send_item(make_req(MODE_INSERT, 5'd5, 32'sd1));      // past count
      send_item(make_req(MODE_INSERT, 5'd31, 32'sd2));
      send_item(make_req(MODE_DELETE, 5'd4, '0));          // at count
      send_item(make_req(MODE_DELETE, 5'd16, '0));
      send_item(make_req(2'd3, 5'd1, $urandom));           // unused mode
      send_item(make_req(MODE_DELETE, 5'd1, $urandom));
      send_item(make_req(MODE_INSERT, 5'd3, 32'shAAAA_AAAA));
      send_item(make_req(MODE_DUMP, 5'd0, '0));
      send_item(make_req(MODE_DELETE, 5'd0, '0));          // head
      send_item(make_req(MODE_DELETE, 5'd2, '0));          // tail
      send_item(make_req(MODE_DUMP, 5'd0, '0));
   endtask

   // Fill to capacity, hit the full-store errors, dump all entries
   task automatic test_full_store();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      while (shadow_list.size() < CAPACITY) begin
         send_item(make_req(MODE_INSERT,
                            POS_W'($urandom_range(0, shadow_list.size())),
                            random_value()));
      end
      send_item(make_req(MODE_INSERT, 5'd0, $urandom));
      send_item(make_req(MODE_INSERT, 5'd16, $urandom));
      send_item(make_req(MODE_DUMP, 5'd0, '0));
      send_item(make_req(MODE_DELETE, 5'd15, '0));
      send_item(make_req(MODE_INSERT, 5'd15, $urandom));
      send_item(make_req(MODE_DUMP, 5'd0, '0));
   endtask

   task automatic run_random_phase(input int n, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (n) send_item(random_list_req());
   endtask

   task automatic test_random_no_idle();
      run_random_phase(80, 0, 0);
   endtask

   task automatic test_random_sender_idle();
      run_random_phase(80, 72, 0);
   endtask

   task automatic test_random_receiver_stall();
      run_random_phase(80, 0, 72);
   endtask

   task automatic test_random_both_idle();
      run_random_phase(80, 38, 38);
   endtask

   // Test sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_full_store();
      test_random_no_idle();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();
      req_valid <= 1'b0;
      rsp_stall_pct = 0;
      while (due_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // No transfer for too long: the block is hung
   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
